[design/pfri_pkg.sv]
// shared types, constants and generator helpers for the per-disk fault injector
package pfri_pkg;

	localparam int unsigned MT_N = 312;
	localparam int unsigned MT_M = 156;
	localparam logic [63:0] MT_MAT = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] MT_UP = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] MT_LO = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SEED_MUL = 64'd6364136223846793005;
	localparam logic [61:0] DEFAULT_RATE = 62'd1000000000;

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_REINIT = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_INTERVAL = 2'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] disk;
	} item_t;

	typedef struct packed {
		logic        fault;
		logic [63:0] total_faults;
		logic [63:0] disk_accesses;
	} result_t;

	typedef enum logic [1:0] {
		OP_ACCESS,
		OP_QUERY,
		OP_REINIT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] disk;
		logic       ok;
	} cmd_t;

	function automatic logic [63:0] mix_word(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] far);
		logic [63:0] x;
		x = (a & MT_UP) | (b & MT_LO);
		return far ^ (x >> 1) ^ (x[0] ? MT_MAT : 64'd0);
	endfunction

	function automatic logic [63:0] temper(input logic [63:0] w);
		logic [63:0] x;
		x = w;
		x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
		x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
		x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
		x = x ^ (x >> 43);
		return x;
	endfunction

endpackage

[design/pfri_ram.sv]
// generic ram, one write port and two registered read ports
module pfri_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2496
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

[design/pfri_front.sv]
// input acceptance, item classification and two-entry command queue
module pfri_front
	import pfri_pkg::*;
#(
	parameter int NUM_DISKS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  hold,
	output logic  cmd_avail,
	output cmd_t  cmd,
	input  logic  cmd_pop
);
	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.disk = item.disk;
		cls.ok = (int'(item.disk) < NUM_DISKS);
		case (item.kind)
			KIND_ACCESS: cls.op = cls.ok ? OP_ACCESS : OP_NOP;
			KIND_QUERY:  cls.op = cls.ok ? OP_QUERY : OP_NOP;
			KIND_REINIT: cls.op = OP_REINIT;
			default:     cls.op = OP_NOP;
		endcase
	end

	assign item_stall = hold || (cnt_q == 2'd2);
	assign push = item_valid && !item_stall;
	assign cmd_avail = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

[design/pfri_back.sv]
// command engine: generator seeding, twist, draw, modulo and result register
module pfri_back
	import pfri_pkg::*;
#(
	parameter int NUM_DISKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  logic        enable,
	input  logic [61:0] mean_interval,
	output logic        busy_init,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result
);
	localparam int DW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
	localparam int DEPTH = NUM_DISKS * MT_N;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SD_WR, ST_ML0, ST_ML1, ST_ML2, ST_ML3, ST_DR_CHK, ST_TW_START,
		ST_TW_LOAD, ST_TW_RD, ST_TW_WR, ST_DR_RD, ST_DR_TMP, ST_DIV, ST_DR_END, ST_FIN
	} state_t;

	state_t         state_q;
	logic           init_q;
	logic           qdraw_q;
	logic           hit_q;
	cmd_t           cmd_q;
	logic [DW-1:0]  dsel_q;
	logic [DW-1:0]  dcnt_q;
	logic [8:0]     sidx_q;
	logic [8:0]     tw_q;
	logic [63:0]    p_q;
	logic [63:0]    x_q;
	logic [63:0]    acc_q;
	logic [63:0]    prod_q;
	logic [63:0]    cur_q;
	logic [63:0]    dvd_q;
	logic [63:0]    rem_q;
	logic [5:0]     dcyc_q;
	logic [63:0]    span_q;
	logic [63:0]    total_q;
	logic [8:0]     pos_q [NUM_DISKS];
	logic [63:0]    accs_q [NUM_DISKS];
	logic [63:0]    cdn_q [NUM_DISKS];

	logic [DW-1:0]  dix;
	logic [AW-1:0]  base;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic [AW-1:0]  waddr;
	logic [63:0]    wdata;
	logic           we;
	logic [63:0]    rdata_a;
	logic [63:0]    rdata_b;
	logic [31:0]    mul_a;
	logic [31:0]    mul_b;
	logic [63:0]    mul_p;
	logic [63:0]    rsh;
	logic [63:0]    rem_n;
	logic [8:0]     far;
	logic [8:0]     nxt;
	logic [61:0]    rate;
	logic [63:0]    cdv;
	logic           hit;

	assign dix = DW'(cmd.disk);
	assign base = AW'(dsel_q * MT_N);
	assign far = (tw_q < 9'(MT_N - MT_M)) ? tw_q + 9'(MT_M) : tw_q - 9'(MT_N - MT_M);
	assign nxt = (tw_q == 9'(MT_N - 1)) ? 9'd0 : tw_q + 9'd1;
	assign rate = (mean_interval == 62'd0) ? 62'd1 : mean_interval;
	assign cdv = cdn_q[dix];
	assign hit = enable && (cdv == 64'd0 || cdv[63]);
	assign busy_init = init_q;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_avail;

	always_comb begin
		raddr_a = base;
		raddr_b = base;
		we = 1'b0;
		waddr = base + AW'(tw_q);
		wdata = mix_word(cur_q, rdata_a, rdata_b);
		case (state_q)
			ST_SD_WR: begin
				we = 1'b1;
				waddr = AW'(dcnt_q * MT_N) + AW'(sidx_q);
				wdata = p_q;
			end
			ST_TW_RD: begin
				raddr_a = base + AW'(nxt);
				raddr_b = base + AW'(far);
			end
			ST_TW_WR: we = 1'b1;
			ST_DR_RD: raddr_a = base + AW'(pos_q[dsel_q]);
			default: ;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_ML1:  begin mul_a = x_q[63:32]; mul_b = SEED_MUL[31:0]; end
			ST_ML2:  begin mul_a = x_q[31:0]; mul_b = SEED_MUL[63:32]; end
			default: begin mul_a = x_q[31:0]; mul_b = SEED_MUL[31:0]; end
		endcase
		mul_p = mul_a * mul_b;
	end

	assign rsh = {rem_q[62:0], dvd_q[63]};
	assign rem_n = (rsh >= span_q) ? rsh - span_q : rsh;

	pfri_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_words (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SD_WR;
			init_q <= 1'b1;
			qdraw_q <= 1'b0;
			hit_q <= 1'b0;
			dcnt_q <= '0;
			sidx_q <= '0;
			p_q <= 64'd1;
			span_q <= {1'b0, DEFAULT_RATE, 1'b0};
			total_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_FIN) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						cmd_q <= cmd;
						dsel_q <= dix;
						hit_q <= (cmd.op == OP_QUERY) && hit;
						case (cmd.op)
							OP_ACCESS: begin
								accs_q[dix] <= accs_q[dix] + 64'd1;
								cdn_q[dix] <= cdv - 64'd1;
								state_q <= ST_FIN;
							end
							OP_QUERY: begin
								if (hit) begin
									total_q <= total_q + 64'd1;
									qdraw_q <= 1'b1;
									state_q <= ST_DR_CHK;
								end else begin
									state_q <= ST_FIN;
								end
							end
							OP_REINIT: begin
								span_q <= {1'b0, rate, 1'b0};
								p_q <= 64'd1;
								sidx_q <= '0;
								dcnt_q <= '0;
								qdraw_q <= 1'b0;
								state_q <= ST_SD_WR;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SD_WR: begin
					if (dcnt_q == DW'(NUM_DISKS - 1)) begin
						dcnt_q <= '0;
						if (sidx_q == 9'(MT_N - 1)) begin
							for (int d = 0; d < NUM_DISKS; d++) begin
								pos_q[d] <= 9'(MT_N);
								accs_q[d] <= '0;
							end
							dsel_q <= '0;
							state_q <= ST_DR_CHK;
						end else begin
							x_q <= p_q ^ (p_q >> 62);
							acc_q <= 64'(sidx_q) + 64'd1;
							state_q <= ST_ML0;
						end
					end else begin
						dcnt_q <= dcnt_q + DW'(1);
					end
				end
				ST_ML0: begin
					prod_q <= mul_p;
					state_q <= ST_ML1;
				end
				ST_ML1: begin
					acc_q <= acc_q + prod_q;
					prod_q <= mul_p;
					state_q <= ST_ML2;
				end
				ST_ML2: begin
					acc_q <= acc_q + (prod_q << 32);
					prod_q <= mul_p;
					state_q <= ST_ML3;
				end
				ST_ML3: begin
					p_q <= acc_q + (prod_q << 32);
					sidx_q <= sidx_q + 9'd1;
					state_q <= ST_SD_WR;
				end
				ST_DR_CHK: begin
					state_q <= (pos_q[dsel_q] >= 9'(MT_N)) ? ST_TW_START : ST_DR_RD;
				end
				ST_TW_START: begin
					tw_q <= '0;
					state_q <= ST_TW_LOAD;
				end
				ST_TW_LOAD: begin
					cur_q <= rdata_a;
					state_q <= ST_TW_RD;
				end
				ST_TW_RD: state_q <= ST_TW_WR;
				ST_TW_WR: begin
					cur_q <= rdata_a;
					if (tw_q == 9'(MT_N - 1)) begin
						pos_q[dsel_q] <= '0;
						state_q <= ST_DR_RD;
					end else begin
						tw_q <= tw_q + 9'd1;
						state_q <= ST_TW_RD;
					end
				end
				ST_DR_RD: begin
					pos_q[dsel_q] <= pos_q[dsel_q] + 9'd1;
					state_q <= ST_DR_TMP;
				end
				ST_DR_TMP: begin
					dvd_q <= temper(rdata_a);
					rem_q <= '0;
					dcyc_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_n;
					dvd_q <= dvd_q << 1;
					dcyc_q <= dcyc_q + 6'd1;
					if (dcyc_q == 6'd63) begin
						state_q <= ST_DR_END;
					end
				end
				ST_DR_END: begin
					if (qdraw_q) begin
						cdn_q[dsel_q] <= rem_q + 64'd1;
						qdraw_q <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						cdn_q[dsel_q] <= rem_q;
						if (dsel_q == DW'(NUM_DISKS - 1)) begin
							init_q <= 1'b0;
							state_q <= init_q ? ST_IDLE : ST_FIN;
						end else begin
							dsel_q <= dsel_q + DW'(1);
							state_q <= ST_DR_CHK;
						end
					end
				end
				ST_FIN: begin
					if (!result_valid || !result_stall) begin
						result_valid <= 1'b1;
						result.fault <= hit_q;
						result.total_faults <= total_q;
						result.disk_accesses <= (cmd_q.ok && cmd_q.op != OP_REINIT) ?
							accs_q[dsel_q] : 64'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/per_disk_random_fault_injector.sv]
// top level: configuration registers, front end and command engine
// Each disk has an MT19937-64 generator held in one shared word memory of
// NUM_DISKS*312 words. After reset the block reseeds every disk and draws
// its first countdown, seeding all words and then twisting and drawing once
// per disk, and no word is taken meanwhile. An access word or a query that
// injects no fault goes straight to the result register; a query that injects
// a fault reads and tempers a word and reduces it with a bit-serial modulo,
// and first twists the generator, one word at a time through the single
// memory write port, when all its words have been used. A reinit word runs
// the same reseed and first draw as reset. mean_interval takes effect at the
// next reinit word.
module per_disk_random_fault_injector
	import pfri_pkg::*;
#(
	parameter int NUM_DISKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [61:0] wr_data
);
	logic        enable_q;
	logic [61:0] interval_q;
	logic        busy_init;
	logic        cmd_avail;
	logic        cmd_pop;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			interval_q <= DEFAULT_RATE;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE:   enable_q <= wr_data[0];
				REG_INTERVAL: interval_q <= wr_data;
				default: ;
			endcase
		end
	end

	pfri_front #(
		.NUM_DISKS(NUM_DISKS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.hold(busy_init),
		.cmd_avail(cmd_avail),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	pfri_back #(
		.NUM_DISKS(NUM_DISKS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(cmd_avail),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.enable(enable_q),
		.mean_interval(interval_q),
		.busy_init(busy_init),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);
endmodule

[verif/per_disk_random_fault_injector_tb.sv]
// testbench for the per-disk random fault injector: directed and random words against a predictor
module per_disk_random_fault_injector_tb;
	import pfri_pkg::*;

	localparam int NDISK = 8;
	localparam int GEN_WORDS = 312;
	localparam int GEN_MID = 156;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;
	localparam logic [61:0] INTERVAL_MAX = {62{1'b1}};
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [61:0] wr_data = '0;

	per_disk_random_fault_injector #(.NUM_DISKS(NDISK)) u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	logic [63:0] gen_word [NDISK][GEN_WORDS];
	int          gen_pos [NDISK];
	logic [63:0] access_cnt [NDISK];
	logic [63:0] countdown [NDISK];
	logic [63:0] fault_cnt [NDISK];
	logic [61:0] rate_held;
	logic [61:0] interval_reg;
	logic        enable_reg;

	result_t     pending_results [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          quiet = 0;

	function automatic logic [63:0] twist_mix(logic [63:0] a, logic [63:0] b, logic [63:0] far);
		logic [63:0] x;
		x = (a & 64'hFFFF_FFFF_8000_0000) | (b & 64'h0000_0000_7FFF_FFFF);
		return far ^ (x >> 1) ^ (x[0] ? 64'hB502_6F5A_A966_19E9 : 64'd0);
	endfunction

	function automatic void seed_gen(int d);
		logic [63:0] p;
		gen_word[d][0] = 64'd1;
		for (int i = 1; i < GEN_WORDS; i++) begin
			p = gen_word[d][i-1];
			gen_word[d][i] = 64'd6364136223846793005 * (p ^ (p >> 62)) + 64'(i);
		end
		gen_pos[d] = GEN_WORDS;
	endfunction

	function automatic logic [63:0] next_draw(int d);
		logic [63:0] x;
		int i;
		if (gen_pos[d] >= GEN_WORDS) begin
			for (i = 0; i < GEN_WORDS - GEN_MID; i++)
				gen_word[d][i] = twist_mix(gen_word[d][i], gen_word[d][i+1], gen_word[d][i+GEN_MID]);
			for (; i < GEN_WORDS - 1; i++)
				gen_word[d][i] = twist_mix(gen_word[d][i], gen_word[d][i+1],
					gen_word[d][i-(GEN_WORDS-GEN_MID)]);
			gen_word[d][GEN_WORDS-1] = twist_mix(gen_word[d][GEN_WORDS-1], gen_word[d][0],
				gen_word[d][GEN_MID-1]);
			gen_pos[d] = 0;
		end
		x = gen_word[d][gen_pos[d]];
		gen_pos[d]++;
		x ^= (x >> 29) & 64'h5555_5555_5555_5555;
		x ^= (x << 17) & 64'h71D6_7FFF_EDA6_0000;
		x ^= (x << 37) & 64'hFFF7_EEE0_0000_0000;
		x ^= (x >> 43);
		return x;
	endfunction

	function automatic logic [63:0] draw_span();
		logic [63:0] r;
		r = (rate_held == '0) ? 64'd1 : {2'b00, rate_held};
		return r << 1;
	endfunction

	function automatic void reseed_all(logic [61:0] rate);
		rate_held = rate;
		for (int d = 0; d < NDISK; d++) begin
			seed_gen(d);
			access_cnt[d] = '0;
			countdown[d] = next_draw(d) % draw_span();
		end
	endfunction

	function automatic result_t predict_word(item_t w);
		result_t r;
		int d;
		logic [63:0] c;
		d = w.disk;
		r = '0;
		case (w.kind)
			KIND_REINIT: reseed_all(interval_reg);
			KIND_ACCESS: begin
				access_cnt[d]++;
				countdown[d]--;
			end
			KIND_QUERY: begin
				c = countdown[d];
				if (enable_reg && (c == '0 || c[63])) begin
					fault_cnt[d]++;
					countdown[d] = 64'd1 + next_draw(d) % draw_span();
					r.fault = 1'b1;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NDISK; i++)
			r.total_faults += fault_cnt[i];
		r.disk_accesses = (w.kind == KIND_REINIT) ? 64'd0 : access_cnt[d];
		return r;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL per_disk_random_fault_injector");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected word", 64'd0, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (result.fault !== want.fault) report("fault", result.fault, want.fault);
				if (result.total_faults !== want.total_faults)
					report("total_faults", result.total_faults, want.total_faults);
				if (result.disk_accesses !== want.disk_accesses)
					report("disk_accesses", result.disk_accesses, want.disk_accesses);
			end
		end
	end

	// receiver stall bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [1:0] k, input logic [2:0] d);
		item_t w;
		w.kind = k;
		w.disk = d;
		item <= w;
		item_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!item_stall) break;
		end
		pending_results.push_back(predict_word(w));
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [61:0] val);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_ENABLE) enable_reg = val[0];
		else if (idx == REG_INTERVAL) interval_reg = val;
		@(posedge clk);
	endtask

	task automatic rand_traffic(input int n, input int reinit_odds);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (reinit_odds > 0 && $urandom_range(1, reinit_odds) == 1)
				send_word(KIND_REINIT, 3'($urandom_range(0, 7)));
			else if (pick < 3)
				send_word(KIND_UNUSED, 3'($urandom_range(0, 7)));
			else if (pick < 55)
				send_word(KIND_ACCESS, 3'($urandom_range(0, 7)));
			else
				send_word(KIND_QUERY, 3'($urandom_range(0, 7)));
		end
	endtask

	task automatic test_after_reset();
		for (int d = 0; d < NDISK; d++) send_word(KIND_ACCESS, 3'(d));
		send_word(KIND_QUERY, 3'd0);
		send_word(KIND_QUERY, 3'd7);
		send_word(KIND_UNUSED, 3'd7);
		send_word(KIND_UNUSED, 3'd0);
	endtask

	task automatic test_unit_interval();
		write_reg(REG_ENABLE, 62'd1);
		write_reg(REG_INTERVAL, 62'd1);
		send_word(KIND_REINIT, 3'd5);
		for (int i = 0; i < 4; i++) begin
			send_word(KIND_QUERY, 3'd2);
			send_word(KIND_ACCESS, 3'd2);
		end
		send_word(KIND_QUERY, 3'd7);
	endtask

	task automatic test_zero_and_max_interval();
		write_reg(REG_INTERVAL, 62'd0);
		write_reg(REG_SPARE_LO, INTERVAL_MAX);
		write_reg(REG_SPARE_HI, 62'd7);
		send_word(KIND_REINIT, 3'd0);
		send_word(KIND_ACCESS, 3'd3);
		send_word(KIND_QUERY, 3'd3);
		send_word(KIND_QUERY, 3'd3);
		write_reg(REG_INTERVAL, INTERVAL_MAX);
		send_word(KIND_REINIT, 3'd7);
		send_word(KIND_QUERY, 3'd1);
	endtask

	task automatic test_enable_off();
		write_reg(REG_ENABLE, 62'h2AAA_AAAA_AAAA_AAAA);
		write_reg(REG_INTERVAL, 62'd2);
		send_word(KIND_REINIT, 3'd0);
		for (int i = 0; i < 4; i++) send_word(KIND_ACCESS, 3'd4);
		send_word(KIND_QUERY, 3'd4);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_ENABLE, 62'($urandom_range(0, 3) != 0) |
				62'({$urandom, $urandom} << 1));
			if (ph == 5)
				write_reg(REG_INTERVAL, 62'({$urandom, $urandom}));
			else
				write_reg(REG_INTERVAL, 62'($urandom_range(1, 6)));
			send_word(KIND_REINIT, 3'($urandom_range(0, 7)));
			rand_traffic(140, 400);
		end
	endtask

	task automatic test_no_idle();
		write_reg(REG_ENABLE, 62'd1);
		write_reg(REG_INTERVAL, 62'd3);
		quiet = 1;
		send_word(KIND_REINIT, 3'd0);
		rand_traffic(160, 0);
	endtask

	initial begin
		enable_reg = 1'b0;
		interval_reg = DEFAULT_RATE;
		for (int d = 0; d < NDISK; d++) fault_cnt[d] = '0;
		reseed_all(DEFAULT_RATE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_unit_interval();
		test_zero_and_max_interval();
		test_enable_off();
		test_random();
		test_no_idle();
		drain();
		if (mismatches == 0)
			$display("PASS per_disk_random_fault_injector");
		else
			$display("FAIL per_disk_random_fault_injector");
		$finish;
	end

endmodule
